@@ design/mfde_pkg.sv @@
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types, codes and font data for the monochrome frame store engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mfde_pkg;

  typedef enum logic [1:0] {
    OP_PLOT   = 2'd0,
    OP_NUMBER = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RMW,
    ST_NUM,
    ST_CLR,
    ST_FIN
  } state_t;

  localparam logic [1:0] COLOR_BLACK  = 2'd0;
  localparam logic [1:0] COLOR_WHITE  = 2'd1;
  localparam logic [1:0] COLOR_INVERT = 2'd2;
  localparam logic [1:0] COLOR_KEEP   = 2'd3;

  localparam logic [6:0] MAX_NUMBER = 7'd99;
  localparam logic [2:0] LAST_ROW   = 3'd4;

  localparam logic [3:0] GLYPH_ROWS [0:9][0:4] = '{
    '{4'd14, 4'd10, 4'd10, 4'd10, 4'd14},
    '{4'd4,  4'd12, 4'd4,  4'd4,  4'd14},
    '{4'd14, 4'd2,  4'd14, 4'd8,  4'd14},
    '{4'd14, 4'd2,  4'd14, 4'd2,  4'd14},
    '{4'd10, 4'd10, 4'd14, 4'd2,  4'd2},
    '{4'd14, 4'd8,  4'd14, 4'd2,  4'd14},
    '{4'd8,  4'd8,  4'd14, 4'd10, 4'd14},
    '{4'd14, 4'd2,  4'd2,  4'd2,  4'd2},
    '{4'd14, 4'd10, 4'd14, 4'd10, 4'd14},
    '{4'd14, 4'd10, 4'd14, 4'd2,  4'd2}
  };

  // Split a value of at most 99 into tens and ones: tens in [7:4], ones in [3:0].
  function automatic logic [7:0] dec_split(input logic [6:0] value);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(value) * 15'd205;
    tens = prod[14:11];
    ones = value - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ design/mfde_store.sv @@
// ----------------------------------------------------------------------------
// mfde_store
// Frame store RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfde_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/mono_framebuffer_draw_engine.sv @@
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// Drawing engine over a one-bit-per-pixel frame store (plot, number, clear, read).
// ----------------------------------------------------------------------------
// One item is worked at a time, all through the single write port of the
// frame store. A plot reads the byte, then modifies it and writes it back; a
// read reads the byte and returns it. An item rejected for range or a plot with
// the keep colour goes straight to the finish state. A number draw writes five
// rows and then finishes, and a clear writes the store one byte a cycle. After
// reset the store is swept to zero before in_ready rises.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module mono_framebuffer_draw_engine #(
  parameter int ROW_BYTES   = 8,
  parameter int STORE_BYTES = 512
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [5:0] pixel_x,
  input  wire logic [5:0] pixel_y,
  input  wire logic [1:0] pixel_color,
  input  wire logic       number_slot,
  input  wire logic [6:0] number_value,
  input  wire logic [8:0] read_address,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            status,
  output logic [7:0]      read_data
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW = $clog2(64 * ROW_BYTES + STORE_BYTES + 512);

  localparam logic [CW-1:0] ROW_C   = CW'(ROW_BYTES);
  localparam logic [CW-1:0] ROW4_C  = CW'(4 * ROW_BYTES);
  localparam logic [CW-1:0] STORE_C = CW'(STORE_BYTES);
  localparam logic [CW-1:0] COL0_C  = CW'(1);
  localparam logic [CW-1:0] COL1_C  = CW'(ROW_BYTES / 2 + 1);
  localparam logic [AW-1:0] ROW_STEP = AW'(ROW_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  mfde_pkg::state_t state, state_next;

  logic          accept;
  logic          out_free;
  logic [CW-1:0] plot_idx;
  logic [CW-1:0] num_col;
  logic [CW-1:0] rd_addr_w;
  logic          plot_ok;
  logic          num_ok;
  logic          read_ok;
  logic [7:0]    digits;

  logic [1:0]    op_q;
  logic [1:0]    color_q;
  logic [7:0]    mask_q;
  logic [AW-1:0] addr_q;
  logic [3:0]    tens_q;
  logic [3:0]    ones_q;
  logic [2:0]    row_q;
  logic          res_status;
  logic [7:0]    res_data;

  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [7:0]    rmw_byte;
  logic [7:0]    rmw_data;
  logic          out_load;
  logic          out_load_status;
  logic [7:0]    out_load_data;

  assign in_ready = (state == mfde_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign plot_idx  = CW'(pixel_y) * ROW_C + CW'(pixel_x[5:3]);
  assign plot_ok   = (CW'(pixel_x[5:3]) < ROW_C) && (plot_idx < STORE_C);
  assign num_col   = number_slot ? COL1_C : COL0_C;
  assign num_ok    = (number_value <= mfde_pkg::MAX_NUMBER) && (num_col < ROW_C) &&
                     ((ROW4_C + num_col) < STORE_C);
  assign rd_addr_w = CW'(read_address);
  assign read_ok   = rd_addr_w < STORE_C;
  assign digits    = mfde_pkg::dec_split(number_value);

  assign mem_raddr = (opcode == mfde_pkg::OP_READ) ? rd_addr_w[AW-1:0] : plot_idx[AW-1:0];

  mfde_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_q),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    case (color_q)
      mfde_pkg::COLOR_BLACK:  rmw_byte = mem_rdata & ~mask_q;
      mfde_pkg::COLOR_WHITE:  rmw_byte = mem_rdata | mask_q;
      mfde_pkg::COLOR_INVERT: rmw_byte = mem_rdata ^ mask_q;
      default:                rmw_byte = mem_rdata;
    endcase
    rmw_data = (op_q == mfde_pkg::OP_READ) ? mem_rdata : 8'd0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mfde_pkg::ST_INIT: begin
        if (addr_q == LAST_ADDR) state_next = mfde_pkg::ST_IDLE;
      end
      mfde_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mfde_pkg::op_t'(opcode))
            mfde_pkg::OP_PLOT: begin
              if (plot_ok && pixel_color != mfde_pkg::COLOR_KEEP) begin
                state_next = mfde_pkg::ST_RMW;
              end else begin
                state_next = mfde_pkg::ST_FIN;
              end
            end
            mfde_pkg::OP_NUMBER: begin
              state_next = num_ok ? mfde_pkg::ST_NUM : mfde_pkg::ST_FIN;
            end
            mfde_pkg::OP_CLEAR: state_next = mfde_pkg::ST_CLR;
            mfde_pkg::OP_READ: begin
              state_next = read_ok ? mfde_pkg::ST_RMW : mfde_pkg::ST_FIN;
            end
          endcase
        end
      end
      mfde_pkg::ST_RMW: begin
        state_next = out_free ? mfde_pkg::ST_IDLE : mfde_pkg::ST_FIN;
      end
      mfde_pkg::ST_NUM: begin
        if (row_q == mfde_pkg::LAST_ROW) state_next = mfde_pkg::ST_FIN;
      end
      mfde_pkg::ST_CLR: begin
        if (addr_q == LAST_ADDR) state_next = mfde_pkg::ST_FIN;
      end
      mfde_pkg::ST_FIN: begin
        if (out_free) state_next = mfde_pkg::ST_IDLE;
      end
      default: state_next = mfde_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    mem_we          = 1'b0;
    mem_wdata       = 8'd0;
    out_load        = 1'b0;
    out_load_status = res_status;
    out_load_data   = res_data;
    unique case (state)
      mfde_pkg::ST_INIT,
      mfde_pkg::ST_CLR: begin
        mem_we = 1'b1;
      end
      mfde_pkg::ST_RMW: begin
        mem_we          = (op_q == mfde_pkg::OP_PLOT);
        mem_wdata       = rmw_byte;
        out_load        = out_free;
        out_load_status = 1'b0;
        out_load_data   = rmw_data;
      end
      mfde_pkg::ST_NUM: begin
        mem_we    = 1'b1;
        mem_wdata = {mfde_pkg::GLYPH_ROWS[tens_q][row_q], mfde_pkg::GLYPH_ROWS[ones_q][row_q]};
      end
      mfde_pkg::ST_FIN: begin
        out_load = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfde_pkg::ST_INIT;
      addr_q    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        mfde_pkg::ST_INIT,
        mfde_pkg::ST_CLR: begin
          addr_q <= addr_q + AW'(1);
        end
        mfde_pkg::ST_NUM: begin
          addr_q <= addr_q + ROW_STEP;
        end
        mfde_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (mfde_pkg::op_t'(opcode))
              mfde_pkg::OP_NUMBER: addr_q <= num_col[AW-1:0];
              mfde_pkg::OP_CLEAR:  addr_q <= '0;
              default:             addr_q <= plot_idx[AW-1:0];
            endcase
          end
        end
        default: begin
          addr_q <= addr_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= opcode;
      color_q  <= pixel_color;
      mask_q   <= 8'h80 >> pixel_x[2:0];
      tens_q   <= digits[7:4];
      ones_q   <= digits[3:0];
      row_q    <= '0;
      res_data <= 8'd0;
      case (mfde_pkg::op_t'(opcode))
        mfde_pkg::OP_PLOT:   res_status <= !plot_ok;
        mfde_pkg::OP_NUMBER: res_status <= !num_ok;
        mfde_pkg::OP_READ:   res_status <= !read_ok;
        default:             res_status <= 1'b0;
      endcase
    end else if (state == mfde_pkg::ST_NUM) begin
      row_q <= row_q + 3'd1;
    end else if (state == mfde_pkg::ST_RMW) begin
      res_status <= 1'b0;
      res_data   <= rmw_data;
    end
    if (out_load) begin
      status    <= out_load_status;
      read_data <= out_load_data;
    end
  end

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("item accepted on consecutive cycles");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(addr_q) < STORE_C))
    else $error("frame store write beyond depth");

  a_number_five_rows: assert property (@(posedge clk) disable iff (rst)
    (state == mfde_pkg::ST_NUM && row_q == mfde_pkg::LAST_ROW) |=>
    (state == mfde_pkg::ST_FIN))
    else $error("number draw did not finish after fifth row");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over a waiting result");
`endif

endmodule

`default_nettype wire
